// ----- sv/ia64_pkg.sv -----
// Package for the 64-bit integer ALU core.
// Holds operation and status codes, queue sizes and the item types shared by all modules.
// No dependencies.
package ia64_pkg;

  localparam int MAX_OPERANDS = 4;
  localparam int NUM_OPERANDS = 4;
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW = $clog2(FQ_DEPTH);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW = $clog2(OQ_DEPTH);
  localparam int DIV_STEPS = 64;
  localparam int LAST_STAGE = DIV_STEPS + 1;

  localparam logic [5:0] F_NEG = 6'd0;
  localparam logic [5:0] F_ADD = 6'd1;
  localparam logic [5:0] F_SUB = 6'd2;
  localparam logic [5:0] F_MUL = 6'd3;
  localparam logic [5:0] F_DIV = 6'd4;
  localparam logic [5:0] F_IDIV = 6'd5;
  localparam logic [5:0] F_REM = 6'd6;
  localparam logic [5:0] F_MOD = 6'd7;
  localparam logic [5:0] F_UDIV = 6'd8;
  localparam logic [5:0] F_UREM = 6'd9;
  localparam logic [5:0] F_MIN = 6'd10;
  localparam logic [5:0] F_MAX = 6'd11;
  localparam logic [5:0] F_BAND = 6'd12;
  localparam logic [5:0] F_BOR = 6'd13;
  localparam logic [5:0] F_BNOT = 6'd14;
  localparam logic [5:0] F_BXOR = 6'd15;
  localparam logic [5:0] F_LT = 6'd16;
  localparam logic [5:0] F_LE = 6'd17;
  localparam logic [5:0] F_ULT = 6'd18;
  localparam logic [5:0] F_ULE = 6'd19;
  localparam logic [5:0] F_GT = 6'd20;
  localparam logic [5:0] F_GE = 6'd21;
  localparam logic [5:0] F_UGT = 6'd22;
  localparam logic [5:0] F_UGE = 6'd23;
  localparam logic [5:0] F_LSHIFT = 6'd24;
  localparam logic [5:0] F_RSHIFT = 6'd25;
  localparam logic [5:0] F_ARSHIFT = 6'd26;
  localparam logic [5:0] F_LROTATE = 6'd27;
  localparam logic [5:0] F_RROTATE = 6'd28;
  localparam logic [5:0] F_EXTRACT = 6'd29;
  localparam logic [5:0] F_REPLACE = 6'd30;
  localparam logic [5:0] F_CLAMP = 6'd31;
  localparam logic [5:0] F_BTEST = 6'd32;
  localparam logic [5:0] F_COUNTRZ = 6'd33;
  localparam logic [5:0] F_COUNTLZ = 6'd34;
  localparam logic [5:0] F_BSWAP = 6'd35;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_DIVZERO = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_BADPOS = 3'd3;
  localparam logic [2:0] ST_BADWIDTH = 3'd4;
  localparam logic [2:0] ST_PASTEND = 3'd5;
  localparam logic [2:0] ST_CLAMP = 3'd6;

  typedef struct packed {
    logic [5:0]              func;
    logic [63:0]             a;
    logic [63:0]             b;
    logic [63:0]             c;
    logic [63:0]             d;
    logic [NUM_OPERANDS-1:0] mask;
    logic [2:0]              st;
    logic                    dv;
    logic                    sdv;
  } item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  status;
  } res_t;

endpackage

// ----- sv/ia64_front.sv -----
// Front end of the ALU core: decodes each item and buffers it in a short queue.
// Depends on ia64_pkg.
module ia64_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [5:0]          func,
  input  logic [63:0]         operand_a,
  input  logic [63:0]         operand_b,
  input  logic [63:0]         operand_c,
  input  logic [63:0]         operand_d,
  input  logic [2:0]          operand_count,
  input  logic                hd_pop,
  output logic                hd_empty,
  output ia64_pkg::item_t     hd
);

  ia64_pkg::item_t              q [ia64_pkg::FQ_DEPTH];
  ia64_pkg::item_t              it;
  logic [ia64_pkg::FQ_AW-1:0]   wr_ptr;
  logic [ia64_pkg::FQ_AW-1:0]   rd_ptr;
  logic [ia64_pkg::FQ_AW:0]     cnt;
  logic [2:0]                   csat;
  logic                         do_push;
  logic                         do_pop;

  assign full = (cnt == (ia64_pkg::FQ_AW+1)'(ia64_pkg::FQ_DEPTH));
  assign hd_empty = (cnt == '0);
  assign hd = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = hd_pop && !hd_empty;

  always_comb begin
    csat = operand_count;
    if (csat > 3'(ia64_pkg::MAX_OPERANDS)) csat = 3'(ia64_pkg::MAX_OPERANDS);
    if (csat > 3'(ia64_pkg::NUM_OPERANDS)) csat = 3'(ia64_pkg::NUM_OPERANDS);
    it.func = func;
    it.a = operand_a;
    it.b = operand_b;
    it.c = operand_c;
    it.d = operand_d;
    for (int i = 0; i < ia64_pkg::NUM_OPERANDS; i++) begin
      it.mask[i] = (3'(i) < csat);
    end
    it.dv = (func >= ia64_pkg::F_DIV) && (func <= ia64_pkg::F_UREM);
    it.sdv = (func >= ia64_pkg::F_DIV) && (func <= ia64_pkg::F_MOD);
    it.st = ia64_pkg::ST_OK;
    if (it.dv && operand_b == 64'd0) begin
      it.st = ia64_pkg::ST_DIVZERO;
    end else if ((func == ia64_pkg::F_DIV || func == ia64_pkg::F_IDIV) &&
                 operand_a == 64'h8000_0000_0000_0000 && operand_b == '1) begin
      it.st = ia64_pkg::ST_OVERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= it;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10: cnt <= cnt + 1'b1;
        2'b01: cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ----- sv/ia64_back.sv -----
// Back end of the ALU core: simple operations, a pipelined multiplier and a
// one-bit-per-stage divider pipeline, all in one pipeline. Depends on ia64_pkg.
module ia64_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                hd_empty,
  input  ia64_pkg::item_t     hd,
  output logic                hd_pop,
  input  logic                oq_full,
  output logic                res_push,
  output ia64_pkg::res_t      res
);

  typedef struct packed {
    logic [5:0]  func;
    logic [2:0]  st;
    logic        dv;
    logic        sdv;
    logic        na;
    logic        nb;
    logic        rnz;
    logic [63:0] bval;
    logic [63:0] simple;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] dvsr;
  } stg_t;

  stg_t        stg [ia64_pkg::LAST_STAGE+1];
  stg_t        stn [ia64_pkg::LAST_STAGE+1];
  logic        vld [ia64_pkg::LAST_STAGE+1];
  logic [64:0] sh [ia64_pkg::LAST_STAGE+1];
  logic [64:0] tr [ia64_pkg::LAST_STAGE+1];
  logic        adv;
  logic [63:0] a, b, c, d, v, ops [ia64_pkg::NUM_OPERANDS], m, lm, ma, mb;
  logic [6:0]  cz;
  logic [2:0]  fst;
  logic        left;
  stg_t        lst;
  logic        ndiff;

  function automatic logic [2:0] fld_chk(input logic [63:0] f, input logic [63:0] w);
    logic [2:0] r;
    r = ia64_pkg::ST_OK;
    if (f > 64'd63) r = ia64_pkg::ST_BADPOS;
    else if (w[63] || w == 64'd0) r = ia64_pkg::ST_BADWIDTH;
    else if (w > (64'd64 - f)) r = ia64_pkg::ST_PASTEND;
    return r;
  endfunction

  assign adv = !vld[ia64_pkg::LAST_STAGE] || !oq_full;
  assign hd_pop = adv && !hd_empty;
  assign res_push = vld[ia64_pkg::LAST_STAGE] && !oq_full;

  always_comb begin
    a = hd.a;
    b = hd.b;
    c = hd.c;
    d = hd.d;
    ops[0] = a;
    ops[1] = b;
    ops[2] = c;
    ops[3] = d;
    v = '0;
    fst = hd.st;
    m = b[63] ? (~b + 64'd1) : b;
    lm = '0;
    cz = 7'd64;
    left = 1'b0;
    ma = a[63] ? (~a + 64'd1) : a;
    mb = m;
    case (hd.func)
      ia64_pkg::F_NEG: v = ~a + 64'd1;
      ia64_pkg::F_ADD: v = a + b;
      ia64_pkg::F_SUB: v = a - b;
      ia64_pkg::F_MIN: begin
        v = 64'h7FFF_FFFF_FFFF_FFFF;
        for (int i = 0; i < ia64_pkg::NUM_OPERANDS; i++) begin
          if (hd.mask[i] && $signed(ops[i]) < $signed(v)) v = ops[i];
        end
      end
      ia64_pkg::F_MAX: begin
        v = 64'h8000_0000_0000_0000;
        for (int i = 0; i < ia64_pkg::NUM_OPERANDS; i++) begin
          if (hd.mask[i] && $signed(v) < $signed(ops[i])) v = ops[i];
        end
      end
      ia64_pkg::F_BAND, ia64_pkg::F_BTEST: begin
        v = '1;
        for (int i = 0; i < ia64_pkg::NUM_OPERANDS; i++) begin
          if (hd.mask[i]) v = v & ops[i];
        end
        if (hd.func == ia64_pkg::F_BTEST) v = {63'd0, (v != 64'd0)};
      end
      ia64_pkg::F_BOR: begin
        for (int i = 0; i < ia64_pkg::NUM_OPERANDS; i++) begin
          if (hd.mask[i]) v = v | ops[i];
        end
      end
      ia64_pkg::F_BXOR: begin
        for (int i = 0; i < ia64_pkg::NUM_OPERANDS; i++) begin
          if (hd.mask[i]) v = v ^ ops[i];
        end
      end
      ia64_pkg::F_BNOT: v = ~a;
      ia64_pkg::F_LT: v = {63'd0, $signed(a) < $signed(b)};
      ia64_pkg::F_LE: v = {63'd0, $signed(a) <= $signed(b)};
      ia64_pkg::F_ULT: v = {63'd0, a < b};
      ia64_pkg::F_ULE: v = {63'd0, a <= b};
      ia64_pkg::F_GT: v = {63'd0, $signed(a) > $signed(b)};
      ia64_pkg::F_GE: v = {63'd0, $signed(a) >= $signed(b)};
      ia64_pkg::F_UGT: v = {63'd0, a > b};
      ia64_pkg::F_UGE: v = {63'd0, a >= b};
      ia64_pkg::F_LSHIFT, ia64_pkg::F_RSHIFT: begin
        left = (hd.func == ia64_pkg::F_LSHIFT) ^ b[63];
        if (m <= 64'd63) v = left ? (a << m[5:0]) : (a >> m[5:0]);
      end
      ia64_pkg::F_ARSHIFT: begin
        if (b[63]) begin
          if (!($signed(b) < -64'sd63)) v = a << m[5:0];
        end else if (b > 64'd63) begin
          v = {64{a[63]}};
        end else begin
          v = $unsigned($signed(a) >>> b[5:0]);
        end
      end
      ia64_pkg::F_LROTATE: v = 64'(({a, a} << b[5:0]) >> 64);
      ia64_pkg::F_RROTATE: v = 64'({a, a} >> b[5:0]);
      ia64_pkg::F_EXTRACT: begin
        fst = fld_chk(b, c);
        lm = '1 >> (7'd64 - c[6:0]);
        v = (a >> b[5:0]) & lm;
      end
      ia64_pkg::F_REPLACE: begin
        fst = fld_chk(c, d);
        lm = '1 >> (7'd64 - d[6:0]);
        v = (a & ~(lm << c[5:0])) | ((b & lm) << c[5:0]);
      end
      ia64_pkg::F_CLAMP: begin
        if ($signed(c) < $signed(b)) fst = ia64_pkg::ST_CLAMP;
        else if ($signed(a) < $signed(b)) v = b;
        else if ($signed(c) < $signed(a)) v = c;
        else v = a;
      end
      ia64_pkg::F_COUNTRZ: begin
        for (int i = 63; i >= 0; i--) begin
          if (a[i]) cz = 7'(i);
        end
        v = {57'd0, cz};
      end
      ia64_pkg::F_COUNTLZ: begin
        for (int i = 0; i < 64; i++) begin
          if (a[i]) cz = 7'(63 - i);
        end
        v = {57'd0, cz};
      end
      ia64_pkg::F_BSWAP: begin
        for (int i = 0; i < 8; i++) begin
          v[8*(7-i) +: 8] = a[8*i +: 8];
        end
      end
      default: v = '0;
    endcase

    stn[0].func = hd.func;
    stn[0].st = fst;
    stn[0].dv = hd.dv;
    stn[0].sdv = hd.sdv;
    stn[0].na = a[63];
    stn[0].nb = b[63];
    stn[0].rnz = 1'b0;
    stn[0].bval = b;
    stn[0].simple = v;
    stn[0].rem = '0;
    stn[0].quo = hd.sdv ? ma : a;
    stn[0].dvsr = hd.sdv ? mb : b;
    if (hd.func == ia64_pkg::F_MUL) begin
      stn[0].rem = a[31:0] * b[31:0];
      stn[0].quo = {32'(a[31:0] * b[63:32]), 32'(a[63:32] * b[31:0])};
    end

    for (int k = 1; k <= ia64_pkg::DIV_STEPS; k++) begin
      stn[k] = stg[k-1];
      sh[k] = {stg[k-1].rem, stg[k-1].quo[63]};
      tr[k] = sh[k] - {1'b0, stg[k-1].dvsr};
      if (stg[k-1].dv) begin
        if (!tr[k][64]) begin
          stn[k].rem = tr[k][63:0];
          stn[k].quo = {stg[k-1].quo[62:0], 1'b1};
        end else begin
          stn[k].rem = sh[k][63:0];
          stn[k].quo = {stg[k-1].quo[62:0], 1'b0};
        end
      end else if (k == 1 && stg[0].func == ia64_pkg::F_MUL) begin
        stn[k].rem = stg[0].rem + {stg[0].quo[63:32] + stg[0].quo[31:0], 32'd0};
      end
    end
    sh[0] = '0;
    tr[0] = '0;
    sh[ia64_pkg::LAST_STAGE] = '0;
    tr[ia64_pkg::LAST_STAGE] = '0;

    stn[ia64_pkg::LAST_STAGE] = stg[ia64_pkg::DIV_STEPS];
    stn[ia64_pkg::LAST_STAGE].rnz = (stg[ia64_pkg::DIV_STEPS].rem != 64'd0);
    if (stg[ia64_pkg::DIV_STEPS].sdv) begin
      if (stg[ia64_pkg::DIV_STEPS].na ^ stg[ia64_pkg::DIV_STEPS].nb) begin
        stn[ia64_pkg::LAST_STAGE].quo = ~stg[ia64_pkg::DIV_STEPS].quo + 64'd1;
      end
      if (stg[ia64_pkg::DIV_STEPS].na) begin
        stn[ia64_pkg::LAST_STAGE].rem = ~stg[ia64_pkg::DIV_STEPS].rem + 64'd1;
      end
    end

    lst = stg[ia64_pkg::LAST_STAGE];
    ndiff = lst.rnz && (lst.na ^ lst.nb);
    case (lst.func)
      ia64_pkg::F_MUL, ia64_pkg::F_REM, ia64_pkg::F_UREM: res.value = lst.rem;
      ia64_pkg::F_DIV, ia64_pkg::F_UDIV: res.value = lst.quo;
      ia64_pkg::F_IDIV: res.value = lst.quo - {63'd0, ndiff};
      ia64_pkg::F_MOD: res.value = lst.rem + (ndiff ? lst.bval : 64'd0);
      default: res.value = lst.simple;
    endcase
    if (lst.st != ia64_pkg::ST_OK) res.value = '0;
    res.status = lst.st;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= ia64_pkg::LAST_STAGE; k++) begin
        stg[k] <= stn[k];
      end
    end
    if (rst) begin
      for (int k = 0; k <= ia64_pkg::LAST_STAGE; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= !hd_empty;
      for (int k = 1; k <= ia64_pkg::LAST_STAGE; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

endmodule

// ----- sv/ia64_outq.sv -----
// Result queue of the ALU core: holds finished results until the receiver pops them.
// Depends on ia64_pkg.
module ia64_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            res_push,
  input  ia64_pkg::res_t  res,
  output logic            oq_full,
  input  logic            pop,
  output logic            empty,
  output logic [63:0]     value,
  output logic [2:0]      status
);

  ia64_pkg::res_t              q [ia64_pkg::OQ_DEPTH];
  logic [ia64_pkg::OQ_AW-1:0]  wr_ptr;
  logic [ia64_pkg::OQ_AW-1:0]  rd_ptr;
  logic [ia64_pkg::OQ_AW:0]    cnt;
  logic                        do_pop;

  assign oq_full = (cnt == (ia64_pkg::OQ_AW+1)'(ia64_pkg::OQ_DEPTH));
  assign empty = (cnt == '0);
  assign value = q[rd_ptr].value;
  assign status = q[rd_ptr].status;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (res_push) q[wr_ptr] <= res;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (res_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({res_push, do_pop})
        2'b10: cnt <= cnt + 1'b1;
        2'b01: cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ----- sv/int64_alu_core.sv -----
// Top level of the 64-bit integer ALU core.
// Instantiates ia64_front, ia64_back and ia64_outq; depends on ia64_pkg.
//
// Usage: the input side is a queue. An item (func, four operands and an
// operand count) is taken at a rising edge where push is high and full is low.
// The result side is a queue too. While empty is low the oldest result is on
// value and status, and it is removed at an edge where pop is high.
// Every item gives exactly one result, in the order the items came in.
// All operations share one pipeline of 67 stages: a decode stage, a
// stage for the simple operations and the multiplier partial products,
// 64 divider stages that each retire one quotient bit, and a sign fix-up
// stage. The block accepts one item per cycle, sustained, as long as
// results are popped. When the receiver stops popping, the result queue
// fills, the pipeline holds, the four-entry input queue fills and full
// rises. A synchronous reset empties both queues and drops every item
// in flight.
module int64_alu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [5:0]  func,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  input  logic [63:0] operand_c,
  input  logic [63:0] operand_d,
  input  logic [2:0]  operand_count,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] value,
  output logic [2:0]  status
);

  ia64_pkg::item_t hd;
  ia64_pkg::res_t  res;
  logic            hd_pop;
  logic            hd_empty;
  logic            oq_full;
  logic            res_push;

  ia64_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .func          (func),
    .operand_a     (operand_a),
    .operand_b     (operand_b),
    .operand_c     (operand_c),
    .operand_d     (operand_d),
    .operand_count (operand_count),
    .hd_pop        (hd_pop),
    .hd_empty      (hd_empty),
    .hd            (hd)
  );

  ia64_back u_back (
    .clk      (clk),
    .rst      (rst),
    .hd_empty (hd_empty),
    .hd       (hd),
    .hd_pop   (hd_pop),
    .oq_full  (oq_full),
    .res_push (res_push),
    .res      (res)
  );

  ia64_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .oq_full  (oq_full),
    .pop      (pop),
    .empty    (empty),
    .value    (value),
    .status   (status)
  );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for int64_alu_core, the 64-bit integer ALU.
// It predicts value and status for every accepted item and compares each popped result in order.
// Depends on ia64_pkg and the int64_alu_core RTL.
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic [63:0] value;
    logic [2:0]  status;
  } alu_result_t;

  int unsigned error_count = 0;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic logic slt(input logic [63:0] x, input logic [63:0] y);
    return $signed(x) < $signed(y);
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic logic [2:0] field_status(input logic [63:0] pos, input logic [63:0] w);
    if (pos > 63) return ia64_pkg::ST_BADPOS;
    if (w[63] || w == 0) return ia64_pkg::ST_BADWIDTH;
    if (w > 64 - pos) return ia64_pkg::ST_PASTEND;
    return ia64_pkg::ST_OK;
  endfunction

  function automatic alu_result_t alu_compute(input logic [5:0] f, input logic [63:0] a,
                                              input logic [63:0] b, input logic [63:0] c,
                                              input logic [63:0] d, input logic [2:0] cnt_in);
    alu_result_t r;
    logic [63:0] opv [4];
    logic [63:0] v, q, rm, m;
    logic [2:0] st;
    int n;
    opv[0] = a; opv[1] = b; opv[2] = c; opv[3] = d;
    n = cnt_in;
    if (n > ia64_pkg::MAX_OPERANDS) n = ia64_pkg::MAX_OPERANDS;
    if (n > 4) n = 4;
    v = 0;
    st = ia64_pkg::ST_OK;
    q = 0;
    rm = 0;
    if (f inside {ia64_pkg::F_DIV, ia64_pkg::F_IDIV, ia64_pkg::F_REM, ia64_pkg::F_MOD} &&
        b != 0) begin
      q = mag(a) / mag(b);
      rm = mag(a) % mag(b);
      if (a[63] != b[63]) q = -q;
      if (a[63]) rm = -rm;
    end
    case (f)
      ia64_pkg::F_NEG: v = -a;
      ia64_pkg::F_ADD: v = a + b;
      ia64_pkg::F_SUB: v = a - b;
      ia64_pkg::F_MUL: v = a * b;
      ia64_pkg::F_DIV, ia64_pkg::F_IDIV: begin
        if (b == 0) st = ia64_pkg::ST_DIVZERO;
        else if (a == 64'h8000000000000000 && b == '1) st = ia64_pkg::ST_OVERFLOW;
        else begin
          v = q;
          if (f == ia64_pkg::F_IDIV && rm != 0 && a[63] != b[63]) v = q - 1;
        end
      end
      ia64_pkg::F_REM, ia64_pkg::F_MOD: begin
        if (b == 0) st = ia64_pkg::ST_DIVZERO;
        else begin
          v = rm;
          if (f == ia64_pkg::F_MOD && rm != 0 && a[63] != b[63]) v = rm + b;
        end
      end
      ia64_pkg::F_UDIV: if (b == 0) st = ia64_pkg::ST_DIVZERO; else v = a / b;
      ia64_pkg::F_UREM: if (b == 0) st = ia64_pkg::ST_DIVZERO; else v = a % b;
      ia64_pkg::F_MIN: begin
        v = 64'h7FFFFFFFFFFFFFFF;
        for (int i = 0; i < n; i++) if (slt(opv[i], v)) v = opv[i];
      end
      ia64_pkg::F_MAX: begin
        v = 64'h8000000000000000;
        for (int i = 0; i < n; i++) if (slt(v, opv[i])) v = opv[i];
      end
      ia64_pkg::F_BAND, ia64_pkg::F_BTEST: begin
        v = '1;
        for (int i = 0; i < n; i++) v &= opv[i];
        if (f == ia64_pkg::F_BTEST) v = (v != 0);
      end
      ia64_pkg::F_BOR: for (int i = 0; i < n; i++) v |= opv[i];
      ia64_pkg::F_BNOT: v = ~a;
      ia64_pkg::F_BXOR: for (int i = 0; i < n; i++) v ^= opv[i];
      ia64_pkg::F_LT: v = slt(a, b);
      ia64_pkg::F_LE: v = !slt(b, a);
      ia64_pkg::F_ULT: v = a < b;
      ia64_pkg::F_ULE: v = a <= b;
      ia64_pkg::F_GT: v = slt(b, a);
      ia64_pkg::F_GE: v = !slt(a, b);
      ia64_pkg::F_UGT: v = a > b;
      ia64_pkg::F_UGE: v = a >= b;
      ia64_pkg::F_LSHIFT, ia64_pkg::F_RSHIFT: begin
        m = mag(b);
        if (m <= 63) v = ((f == ia64_pkg::F_LSHIFT) != b[63]) ? a << m : a >> m;
      end
      ia64_pkg::F_ARSHIFT: begin
        if (b[63]) v = slt(b, -64'd63) ? 64'd0 : a << mag(b);
        else if (b > 63) v = {64{a[63]}};
        else v = $signed(a) >>> b;
      end
      ia64_pkg::F_LROTATE: v = (a << b[5:0]) | (a >> (7'd64 - b[5:0]));
      ia64_pkg::F_RROTATE: v = (a >> b[5:0]) | (a << (7'd64 - b[5:0]));
      ia64_pkg::F_EXTRACT: begin
        st = field_status(b, c);
        if (st == ia64_pkg::ST_OK) v = (a >> b) & ({64{1'b1}} >> (64 - c));
      end
      ia64_pkg::F_REPLACE: begin
        st = field_status(c, d);
        if (st == ia64_pkg::ST_OK) begin
          m = {64{1'b1}} >> (64 - d);
          v = (a & ~(m << c)) | ((b & m) << c);
        end
      end
      ia64_pkg::F_CLAMP: begin
        if (slt(c, b)) st = ia64_pkg::ST_CLAMP;
        else if (slt(a, b)) v = b;
        else if (slt(c, a)) v = c;
        else v = a;
      end
      ia64_pkg::F_COUNTRZ: begin
        v = 64;
        for (int i = 63; i >= 0; i--) if (a[i]) v = i;
      end
      ia64_pkg::F_COUNTLZ: begin
        v = 64;
        for (int i = 0; i < 64; i++) if (a[i]) v = 63 - i;
      end
      ia64_pkg::F_BSWAP: for (int i = 0; i < 8; i++) v[8*(7-i) +: 8] = a[8*i +: 8];
      default: v = 0;
    endcase
    if (st != ia64_pkg::ST_OK) v = 0;
    r.value = v;
    r.status = st;
    return r;
  endfunction

  class alu_scoreboard;
    alu_result_t pending[$];
    int unsigned checked = 0;

    function void note_item(logic [5:0] f, logic [63:0] a, logic [63:0] b,
                            logic [63:0] c, logic [63:0] d, logic [2:0] cnt);
      pending.push_back(alu_compute(f, a, b, c, d, cnt));
    endfunction

    task check_result(logic [63:0] v, logic [2:0] st);
      alu_result_t e;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h status=%0d", v, st));
        return;
      end
      e = pending.pop_front();
      if (v !== e.value)
        report_mismatch($sformatf("value %h, expected %h", v, e.value));
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic [5:0] func = 0;
  logic [63:0] operand_a = 0, operand_b = 0, operand_c = 0, operand_d = 0;
  logic [2:0] operand_count = 0;
  logic full, empty;
  logic [63:0] value;
  logic [2:0] status;

  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 64;
  alu_scoreboard board = new();

  int64_alu_core dut (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && !empty && pop) board.check_result(value, status);
    if (!rst) pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(input logic [5:0] f, input logic [63:0] a, input logic [63:0] b,
                           input logic [63:0] c, input logic [63:0] d, input logic [2:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    func <= f;
    operand_a <= a;
    operand_b <= b;
    operand_c <= c;
    operand_d <= d;
    operand_count <= cnt;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_item(f, a, b, c, d, cnt);
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(7))
      0: x = $urandom_range(70);
      1: x = -$urandom_range(70);
      2: x = 64'h8000000000000000;
      3: x = 64'h7FFFFFFFFFFFFFFF;
      4: x = x >> $urandom_range(63);
      default: ;
    endcase
    return x;
  endfunction

  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  localparam logic [63:0] MINV = 64'h8000000000000000;
  localparam logic [63:0] MAXV = 64'h7FFFFFFFFFFFFFFF;

  initial begin
    logic [5:0] f;
    logic [63:0] a, b, c, d;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_item(ia64_pkg::F_NEG, MINV, 0, 0, 0, 0);
    send_item(ia64_pkg::F_ADD, MAXV, 1, 0, 0, 0);
    send_item(ia64_pkg::F_MUL, MAXV, MINV, 0, 0, 0);
    send_item(ia64_pkg::F_DIV, 5, 0, 0, 0, 0);
    send_item(ia64_pkg::F_DIV, MINV, '1, 0, 0, 0);
    send_item(ia64_pkg::F_IDIV, -1, 2, 0, 0, 0);
    send_item(ia64_pkg::F_REM, MINV, '1, 0, 0, 0);
    send_item(ia64_pkg::F_MOD, -7, 3, 0, 0, 0);
    send_item(ia64_pkg::F_UREM, '1, 0, 0, 0, 0);
    send_item(ia64_pkg::F_MIN, 1, 2, 3, 4, 0);
    send_item(ia64_pkg::F_MAX, 1, 2, 3, 4, 7);
    send_item(ia64_pkg::F_BAND, 1, 2, 3, 4, 0);
    send_item(ia64_pkg::F_BTEST, 0, 0, 0, 0, 0);
    send_item(ia64_pkg::F_LSHIFT, '1, 64, 0, 0, 0);
    send_item(ia64_pkg::F_RSHIFT, '1, -63, 0, 0, 0);
    send_item(ia64_pkg::F_ARSHIFT, MINV, 100, 0, 0, 0);
    send_item(ia64_pkg::F_ARSHIFT, MINV, -64, 0, 0, 0);
    send_item(ia64_pkg::F_LROTATE, 64'h1234, -1, 0, 0, 0);
    send_item(ia64_pkg::F_EXTRACT, '1, 64, 1, 0, 0);
    send_item(ia64_pkg::F_EXTRACT, '1, 3, 0, 0, 0);
    send_item(ia64_pkg::F_REPLACE, '1, 0, 60, 5, 0);
    send_item(ia64_pkg::F_CLAMP, 0, 5, 4, 0, 0);
    send_item(ia64_pkg::F_COUNTLZ, 0, 0, 0, 0, 0);
    send_item(ia64_pkg::F_BSWAP, 64'h0102030405060708, 0, 0, 0, 0);
    send_item(6'd63, '1, '1, '1, '1, 7);
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 64; recv_idle_pct = 11; end
      if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int k = 0; k < 360; k++) begin
        f = ($urandom_range(15) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(35));
        a = rand_operand();
        b = rand_operand();
        c = rand_operand();
        d = rand_operand();
        if (f inside {ia64_pkg::F_EXTRACT, ia64_pkg::F_REPLACE} &&
            $urandom_range(3) != 0) begin
          b = $urandom_range(63);
          c = $urandom_range(64);
          if (f == ia64_pkg::F_REPLACE) begin
            c = $urandom_range(63);
            d = $urandom_range(64);
          end
        end
        send_item(f, a, b, c, d, 3'($urandom_range(7)));
        if (k == 180) drain();
      end
      drain();
    end
    repeat (100) @(posedge clk);
    $display("Checked %0d results across directed edge cases and three idling mixes.",
             board.checked);
    if (error_count == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
